// ----- hw/rtl/bwtn_pkg.sv -----
// Package for the bone weight top-four normalizer.
// Channel payload structs, the vertex record passed from front to back, and constants.
// No dependencies.
package bwtn_pkg;

   localparam int OUT_SLOTS  = 4;
   localparam int BONE_COUNT = 256;
   localparam int SUM_W      = 18;
   localparam int WEIGHT_W   = 16;
   localparam int BONE_W     = 8;
   localparam int DVD_W      = 32;
   localparam int DIV_STEPS  = 16;

   localparam logic [SUM_W-1:0]    ONE_Q15       = 18'd32768;
   localparam logic [WEIGHT_W-1:0] TOLERANCE_RST = 16'd33;

   typedef struct packed {
      logic [BONE_W-1:0]   bone_index;
      logic [WEIGHT_W-1:0] bone_weight;
      logic                weight_present;
      logic                vertex_last;
   } req_type;

   typedef struct packed {
      logic [BONE_W-1:0]   slot0_bone;
      logic [BONE_W-1:0]   slot1_bone;
      logic [BONE_W-1:0]   slot2_bone;
      logic [BONE_W-1:0]   slot3_bone;
      logic [WEIGHT_W-1:0] slot0_weight;
      logic [WEIGHT_W-1:0] slot1_weight;
      logic [WEIGHT_W-1:0] slot2_weight;
      logic [WEIGHT_W-1:0] slot3_weight;
      logic [2:0]          influence_count;
   } rsp_type;

   typedef struct packed {
      logic [OUT_SLOTS-1:0][BONE_W-1:0]   bones;
      logic [OUT_SLOTS-1:0][WEIGHT_W-1:0] weights;
      logic [2:0]                         count;
      logic [SUM_W-1:0]                   sum;
   } vertex_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

// ----- hw/rtl/bwtn_front.sv -----
// Front part: accepts bone items and keeps the largest weights of the current vertex.
// Pushes one vertex record into the queue on the last item. Depends on bwtn_pkg.
module bwtn_front #(
   parameter int MAX_INFLUENCES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bwtn_pkg::req_type   req_data,
   output logic                push,
   output bwtn_pkg::vertex_type push_data,
   input  logic                q_full
);
   import bwtn_pkg::*;

   localparam int CW    = $clog2(MAX_INFLUENCES + 1);
   localparam int IW    = (MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1;
   localparam int SHOWN = (MAX_INFLUENCES < OUT_SLOTS) ? MAX_INFLUENCES : OUT_SLOTS;

   logic [BONE_W-1:0]   bones_ff   [MAX_INFLUENCES];
   logic [BONE_W-1:0]   bones_in   [MAX_INFLUENCES];
   logic [WEIGHT_W-1:0] weights_ff [MAX_INFLUENCES];
   logic [WEIGHT_W-1:0] weights_in [MAX_INFLUENCES];
   logic [CW-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [IW-1:0]       mini;
   logic [WEIGHT_W-1:0] minw;
   logic                take, accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign take      = req_data.weight_present &&
                      ({1'b0, req_data.bone_index} < 9'(BONE_COUNT));

   always_comb begin
      bones_in   = bones_ff;
      weights_in = weights_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      mini       = '0;
      minw       = weights_ff[0];
      for (int i = 1; i < MAX_INFLUENCES; i++) begin
         if (weights_ff[i] < minw) begin
            minw = weights_ff[i];
            mini = IW'(i);
         end
      end
      if (take) begin
         if (count_ff < CW'(MAX_INFLUENCES)) begin
            for (int i = 0; i < MAX_INFLUENCES; i++) begin
               if (CW'(i) == count_ff) begin
                  bones_in[i]   = req_data.bone_index;
                  weights_in[i] = req_data.bone_weight;
               end
            end
            count_in = count_ff + CW'(1);
            sum_in   = sum_ff + SUM_W'(req_data.bone_weight);
         end else if (!(req_data.bone_weight < minw)) begin
            for (int i = 0; i < MAX_INFLUENCES - 1; i++) begin
               if (IW'(i) >= mini) begin
                  bones_in[i]   = bones_ff[i + 1];
                  weights_in[i] = weights_ff[i + 1];
               end
            end
            bones_in[MAX_INFLUENCES - 1]   = req_data.bone_index;
            weights_in[MAX_INFLUENCES - 1] = req_data.bone_weight;
            sum_in = sum_ff - SUM_W'(minw) + SUM_W'(req_data.bone_weight);
         end
      end
   end

   always_comb begin
      push_data = '0;
      for (int j = 0; j < SHOWN; j++) begin
         push_data.bones[j]   = bones_in[j];
         push_data.weights[j] = weights_in[j];
      end
      push_data.count = (4'(count_in) > 4'(OUT_SLOTS)) ? 3'(OUT_SLOTS) : 3'(count_in);
      push_data.sum   = sum_in;
   end

   assign push = accept && req_data.vertex_last;

   // Clear the collection after the last item of a vertex
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_INFLUENCES; i++) begin
            bones_ff[i]   <= '0;
            weights_ff[i] <= '0;
         end
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (accept) begin
         if (req_data.vertex_last) begin
            for (int i = 0; i < MAX_INFLUENCES; i++) begin
               bones_ff[i]   <= '0;
               weights_ff[i] <= '0;
            end
            count_ff <= '0;
            sum_ff   <= '0;
         end else begin
            bones_ff   <= bones_in;
            weights_ff <= weights_in;
            count_ff   <= count_in;
            sum_ff     <= sum_in;
         end
      end
   end

endmodule

// ----- hw/rtl/bwtn_queue.sv -----
// Two-entry queue of vertex records between the front and back parts.
// Depends on bwtn_pkg.
module bwtn_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bwtn_pkg::vertex_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output bwtn_pkg::vertex_type pop_data
);
   import bwtn_pkg::*;

   vertex_type  entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_in;
      end
   end

endmodule

// ----- hw/rtl/bwtn_back.sv -----
// Back part: takes vertex records, normalizes the weights with four radix-4 dividers
// that share one divisor, and holds the result in the output register. Depends on bwtn_pkg.
module bwtn_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          tolerance,
   input  logic                 not_empty,
   input  bwtn_pkg::vertex_type pop_data,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bwtn_pkg::rsp_type    rsp_data
);
   import bwtn_pkg::*;

   back_state_type state_ff, state_in;

   logic [OUT_SLOTS-1:0][BONE_W-1:0]   bones_ff;
   logic [OUT_SLOTS-1:0][WEIGHT_W-1:0] quo_ff, quo_in;
   logic [OUT_SLOTS-1:0][DVD_W-1:0]    dvd_ff;
   logic [OUT_SLOTS-1:0][SUM_W-1:0]    rem_ff, rem_in;
   logic [2:0]                         count_ff;
   logic [SUM_W-1:0]                   divisor_ff;
   logic [3:0]                         step_ff;
   logic                               rsp_valid_ff;
   rsp_type                            rsp_ff;

   logic [SUM_W-1:0] sum_gap;
   logic             norm, load_out, div_en;

   always_comb begin
      sum_gap = (pop_data.sum >= ONE_Q15) ? pop_data.sum - ONE_Q15 : ONE_Q15 - pop_data.sum;
      norm    = (sum_gap > SUM_W'(tolerance)) && (pop_data.sum != '0);
   end

   // Two quotient bits per lane and cycle
   always_comb begin
      logic [SUM_W:0]   r1, r2;
      logic [SUM_W-1:0] r1s;
      logic             ge1, ge2;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int j = 0; j < OUT_SLOTS; j++) begin
         r1  = {rem_ff[j], dvd_ff[j][DVD_W-1]};
         ge1 = (r1 >= {1'b0, divisor_ff});
         r1s = ge1 ? SUM_W'(r1 - {1'b0, divisor_ff}) : SUM_W'(r1);
         r2  = {r1s, dvd_ff[j][DVD_W-2]};
         ge2 = (r2 >= {1'b0, divisor_ff});
         rem_in[j] = ge2 ? SUM_W'(r2 - {1'b0, divisor_ff}) : SUM_W'(r2);
         quo_in[j] = {quo_ff[j][WEIGHT_W-3:0], ge1, ge2};
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (not_empty) begin
               state_in = norm ? BK_DIV : BK_DONE;
            end
         end
         BK_DIV: begin
            if (step_ff == 4'(DIV_STEPS - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      div_en   = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         BK_IDLE: pop      = not_empty;
         BK_DIV:  div_en   = 1'b1;
         BK_DONE: load_out = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         bones_ff   <= pop_data.bones;
         count_ff   <= pop_data.count;
         divisor_ff <= pop_data.sum;
         step_ff    <= '0;
         for (int j = 0; j < OUT_SLOTS; j++) begin
            quo_ff[j] <= pop_data.weights[j];
            rem_ff[j] <= '0;
            dvd_ff[j] <= {1'b0, pop_data.weights[j], 15'b0};
         end
      end else if (div_en) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + 4'd1;
         for (int j = 0; j < OUT_SLOTS; j++) begin
            dvd_ff[j] <= {dvd_ff[j][DVD_W-3:0], 2'b00};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff.slot0_bone      <= bones_ff[0];
         rsp_ff.slot1_bone      <= bones_ff[1];
         rsp_ff.slot2_bone      <= bones_ff[2];
         rsp_ff.slot3_bone      <= bones_ff[3];
         rsp_ff.slot0_weight    <= quo_ff[0];
         rsp_ff.slot1_weight    <= quo_ff[1];
         rsp_ff.slot2_weight    <= quo_ff[2];
         rsp_ff.slot3_weight    <= quo_ff[3];
         rsp_ff.influence_count <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/bone_weight_top4_normalizer.sv -----
// Bone weight top-four normalizer, top level: sum tolerance register, front, queue, back.
// Depends on bwtn_pkg, bwtn_front, bwtn_queue and bwtn_back.
//
// Bone items are taken one per cycle while the vertex queue has room; the front keeps the
// MAX_INFLUENCES largest weights of the vertex and, on the item marked last, hands a record
// to a two-entry queue. The back part pops a record, normalizes all four slots at once with
// radix-4 restoring dividers, and then loads the output register. It divides only when the
// sum is off by more than the tolerance and is not zero, else the weights pass unchanged.
// Collection of the next vertices overlaps this work. The tolerance is written through the
// csr port, resets to 33, and is meant to change only when the block is idle.
module bone_weight_top4_normalizer #(
   parameter int MAX_INFLUENCES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bwtn_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bwtn_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);
   import bwtn_pkg::*;

   logic [WEIGHT_W-1:0] tolerance_ff;
   logic                push, pop, q_full, q_not_empty;
   vertex_type          push_data, pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOLERANCE_RST;
      end else if (csr_valid && csr_ready) begin
         tolerance_ff <= csr_data;
      end
   end

   bwtn_front #(
      .MAX_INFLUENCES (MAX_INFLUENCES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   bwtn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_data)
   );

   bwtn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tolerance (tolerance_ff),
      .not_empty (q_not_empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- dv/tb.sv -----
// Self-checking bench for bone_weight_top4_normalizer: random-gap driver, stalling monitor and
// an in-bench top-four/normalize predictor checked against every vertex result.
// Depends on bwtn_pkg and the bone_weight_top4_normalizer RTL.
`timescale 1ns / 100ps

module tb;
   import bwtn_pkg::*;

   localparam int KEEP          = 4;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_BONES   = 355;
   localparam int RUN_LIMIT     = 600000;

   typedef enum logic {ST_BONE, ST_CSR} step_kind_type;

   typedef struct {
      step_kind_type kind;
      req_type       item;
      logic [15:0]   tol;
   } step_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data  = '0;

   step_type    pending[$];
   rsp_type     expected_rsp[$];

   logic [7:0]  held_bone[KEEP];
   logic [15:0] held_wt[KEEP];
   int          held_n   = 0;
   logic [17:0] held_sum = '0;
   logic [15:0] tol_q    = TOLERANCE_RST;

   int err_cnt          = 0;
   int bones_sent       = 0;
   int vertices_checked = 0;
   int csr_writes       = 0;
   int bones_queued     = 0;
   int cycle_cnt        = 0;
   int gap_left         = 0;
   int stall_left       = 0;
   int settle_cnt       = 0;
   bit drv_calm         = 1'b0;
   bit mon_calm         = 1'b0;

   bone_weight_top4_normalizer #(
      .MAX_INFLUENCES(KEEP)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic int clamp_q15(int v);
      if (v < 0) return 0;
      if (v > 32768) return 32768;
      return v;
   endfunction

   task automatic clear_held();
      for (int i = 0; i < KEEP; i++) begin
         held_bone[i] = '0;
         held_wt[i]   = '0;
      end
      held_n   = 0;
      held_sum = '0;
   endtask

   // Update the kept set with one accepted bone; on the last bone, queue the vertex result.
   task automatic absorb_bone(input req_type it);
      int          mi;
      int          shown;
      logic [15:0] mw;
      logic [17:0] sum_gap;
      logic [31:0] scaled;
      bit          rescale;
      logic [7:0]  ob[OUT_SLOTS];
      logic [15:0] ow[OUT_SLOTS];
      rsp_type     r;
      if (it.weight_present && int'(it.bone_index) < BONE_COUNT) begin
         if (held_n < KEEP) begin
            held_bone[held_n] = it.bone_index;
            held_wt[held_n]   = it.bone_weight;
            held_n++;
            held_sum = held_sum + 18'(it.bone_weight);
         end else begin
            mi = 0;
            mw = held_wt[0];
            for (int i = 1; i < KEEP; i++) begin
               if (held_wt[i] < mw) begin
                  mw = held_wt[i];
                  mi = i;
               end
            end
            if (it.bone_weight >= mw) begin
               for (int i = mi; i < KEEP - 1; i++) begin
                  held_bone[i] = held_bone[i+1];
                  held_wt[i]   = held_wt[i+1];
               end
               held_bone[KEEP-1] = it.bone_index;
               held_wt[KEEP-1]   = it.bone_weight;
               held_sum = held_sum - 18'(mw) + 18'(it.bone_weight);
            end
         end
      end
      if (it.vertex_last) begin
         sum_gap = (held_sum >= ONE_Q15) ? held_sum - ONE_Q15 : ONE_Q15 - held_sum;
         rescale = (sum_gap > 18'(tol_q)) && (held_sum != '0);
         shown   = (held_n < OUT_SLOTS) ? held_n : OUT_SLOTS;
         for (int j = 0; j < OUT_SLOTS; j++) begin
            ob[j] = '0;
            ow[j] = '0;
            if (j < shown) begin
               ob[j]  = held_bone[j];
               scaled = 32'(held_wt[j]);
               if (rescale) scaled = (scaled << 15) / 32'(held_sum);
               ow[j] = scaled[15:0];
            end
         end
         r.slot0_bone      = ob[0];
         r.slot1_bone      = ob[1];
         r.slot2_bone      = ob[2];
         r.slot3_bone      = ob[3];
         r.slot0_weight    = ow[0];
         r.slot1_weight    = ow[1];
         r.slot2_weight    = ow[2];
         r.slot3_weight    = ow[3];
         r.influence_count = 3'(shown);
         expected_rsp = {expected_rsp, r};
         clear_held();
      end
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         err_cnt++;
      end
   endtask

   task automatic push_bone(int bone, int weight, bit present, bit last);
      step_type s;
      s.kind                = ST_BONE;
      s.tol                 = '0;
      s.item.bone_index     = 8'(bone);
      s.item.bone_weight    = 16'(weight);
      s.item.weight_present = present;
      s.item.vertex_last    = last;
      pending = {pending, s};
      bones_queued++;
   endtask

   task automatic push_csr(int value);
      step_type s;
      s.kind = ST_CSR;
      s.item = '0;
      s.tol  = 16'(value);
      pending = {pending, s};
   endtask

   // Ascending bones, present weights split from 1.0 and then optionally skewed.
   task automatic add_vertex();
      int n, k, placed, left, pos, mode, first, stride, cap;
      bit on[24];
      int w[24];
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
      k = $urandom_range(1, (n < 8) ? n : 8);
      foreach (on[i]) on[i] = 1'b0;
      placed = 0;
      while (placed < k) begin
         pos = $urandom_range(0, n - 1);
         if (!on[pos]) begin
            on[pos] = 1'b1;
            placed++;
         end
      end
      left   = 32768;
      placed = 0;
      pos    = 0;
      for (int i = 0; i < n; i++) begin
         if (on[i]) begin
            placed++;
            pos = i;
            if (placed == k) begin
               w[i] = left;
            end else begin
               cap  = 2 * left / (k - placed + 1);
               w[i] = $urandom_range(0, (cap < left) ? cap : left);
               left -= w[i];
            end
         end else begin
            w[i] = $urandom_range(0, 32768);
         end
      end
      mode = $urandom_range(0, 3);
      if (mode == 1) begin
         w[pos] = clamp_q15(w[pos] + $urandom_range(0, 80) - 40);
      end else if (mode == 2) begin
         for (int i = 0; i < n; i++)
            if (on[i]) w[i] = clamp_q15(w[i] * $urandom_range(40, 160) / 100);
      end
      first  = $urandom_range(0, 256 - n);
      stride = (n > 1) ? $urandom_range(1, (255 - first) / (n - 1)) : 1;
      for (int i = 0; i < n; i++)
         push_bone(first + i * stride, w[i], on[i], i == n - 1);
   endtask

   task automatic add_noise_vertex();
      int n, wv, r;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         r  = $urandom_range(0, 3);
         wv = (r == 0) ? 0 : (r == 1) ? 32768 : $urandom_range(0, 32768);
         push_bone($urandom_range(0, 255), wv, $urandom_range(0, 1), i == n - 1);
      end
   endtask

   always @(posedge clock) begin : drive_p
      step_type    head;
      logic        nv_req;
      logic        nv_csr;
      req_type     nd_req;
      logic [15:0] nd_csr;
      nv_req = req_valid;
      nd_req = req_data;
      nv_csr = csr_valid;
      nd_csr = csr_data;
      if (reset) begin
         nv_req     = 1'b0;
         nv_csr     = 1'b0;
         gap_left   = 0;
         settle_cnt = 0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_bone(req_data);
            bones_sent++;
            nv_req = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            tol_q = csr_data;
            csr_writes++;
            nv_csr = 1'b0;
         end
         if (expected_rsp.size() == 0 && !req_valid) settle_cnt++;
         else settle_cnt = 0;
         if (!nv_req && !nv_csr) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending.size() > 0) begin
               head = pending[0];
               if (head.kind == ST_BONE) begin
                  void'(pending.pop_front());
                  nv_req   = 1'b1;
                  nd_req   = head.item;
                  gap_left = pick_gap(drv_calm);
                  if ($urandom_range(0, 63) == 0) drv_calm = !drv_calm;
               end else if (settle_cnt >= SETTLE_CYCLES) begin
                  void'(pending.pop_front());
                  nv_csr = 1'b1;
                  nd_csr = head.tol;
               end
            end
         end
      end
      req_valid <= nv_req;
      req_data  <= nd_req;
      csr_valid <= nv_csr;
      csr_data  <= nd_csr;
   end

   always @(posedge clock) begin : watch_p
      rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: result expected none actual %h", $time, rsp_data);
               err_cnt++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("slot0_bone", 16'(want.slot0_bone), 16'(rsp_data.slot0_bone));
               check_field("slot1_bone", 16'(want.slot1_bone), 16'(rsp_data.slot1_bone));
               check_field("slot2_bone", 16'(want.slot2_bone), 16'(rsp_data.slot2_bone));
               check_field("slot3_bone", 16'(want.slot3_bone), 16'(rsp_data.slot3_bone));
               check_field("slot0_weight", want.slot0_weight, rsp_data.slot0_weight);
               check_field("slot1_weight", want.slot1_weight, rsp_data.slot1_weight);
               check_field("slot2_weight", want.slot2_weight, rsp_data.slot2_weight);
               check_field("slot3_weight", want.slot3_weight, rsp_data.slot3_weight);
               check_field("influence_count", 16'(want.influence_count),
                           16'(rsp_data.influence_count));
               vertices_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap(mon_calm);
            if ($urandom_range(0, 63) == 0) mon_calm = !mon_calm;
         end
      end
   end

   always @(posedge clock) begin : limit_p
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == RUN_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stim_p
      int tol_set[4];
      int target;
      clear_held();

      // no present weight
      push_bone(77, 32768, 1'b0, 1'b1);
      // single full weight on the top bone
      push_bone(255, 32768, 1'b1, 1'b1);
      // equal weights: the earliest ones drop out
      for (int i = 0; i < 6; i++) push_bone(i, 8000, 1'b1, i == 5);
      // zero sum
      push_bone(0, 0, 1'b1, 1'b0);
      push_bone(9, 0, 1'b1, 1'b1);
      // weights of 1.0 push the sum far past 1.0
      push_bone(1, 32768, 1'b1, 1'b0);
      push_bone(2, 32768, 1'b1, 1'b0);
      push_bone(3, 100, 1'b1, 1'b1);
      // one kept item, then a skipped item that carries the last mark
      push_bone(170, 12345, 1'b1, 1'b0);
      push_bone(85, 65535, 1'b0, 1'b1);
      // sum within tolerance
      for (int i = 0; i < 4; i++) push_bone(10 + i, (i == 3) ? 8200 : 8192, 1'b1, i == 3);
      // smallest in the middle is evicted, later entries shift down
      push_bone(20, 9000, 1'b1, 1'b0);
      push_bone(21, 3000, 1'b1, 1'b0);
      push_bone(22, 9000, 1'b1, 1'b0);
      push_bone(23, 9000, 1'b1, 1'b0);
      push_bone(24, 9100, 1'b1, 1'b1);

      tol_set[0] = 0;
      tol_set[1] = 32768;
      tol_set[2] = $urandom_range(1, 32767);
      tol_set[3] = $urandom_range(0, 300);
      for (int p = 0; p < 4; p++) begin
         push_csr(tol_set[p]);
         target = bones_queued + PHASE_BONES;
         while (bones_queued < target) begin
            if ($urandom_range(0, 4) == 0) add_noise_vertex();
            else add_vertex();
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid || csr_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d bone transfers and %0d checked vertices", bones_sent,
               vertices_checked);
      $display("across %0d tolerance writes plus the reset tolerance", csr_writes);
      if (err_cnt == 0 && expected_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
